>>> sv/ssh_pkg.sv
package ssh_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int RSP_DATA_W = 40;

   typedef struct packed {
      logic [31:0] word;
      logic        final_word;
   } q_entry_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_PAD_FIRST,
      FRONT_PAD_FILL
   } front_state_type;

   typedef enum logic [1:0] {
      CORE_LOAD,
      CORE_ROUND,
      CORE_ADD,
      CORE_EMIT
   } core_state_type;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] initial_hash(input logic [2:0] idx);
      logic [31:0] v;
      case (idx)
         3'd0: v = 32'h6A09E667;
         3'd1: v = 32'hBB67AE85;
         3'd2: v = 32'h3C6EF372;
         3'd3: v = 32'hA54FF53A;
         3'd4: v = 32'h510E527F;
         3'd5: v = 32'h9B05688C;
         3'd6: v = 32'h1F83D9AB;
         3'd7: v = 32'h5BE0CD19;
         default: v = 32'h6A09E667;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] v;
      case (idx)
         6'd0:  v = 32'h428A2F98;  6'd1:  v = 32'h71374491;
         6'd2:  v = 32'hB5C0FBCF;  6'd3:  v = 32'hE9B5DBA5;
         6'd4:  v = 32'h3956C25B;  6'd5:  v = 32'h59F111F1;
         6'd6:  v = 32'h923F82A4;  6'd7:  v = 32'hAB1C5ED5;
         6'd8:  v = 32'hD807AA98;  6'd9:  v = 32'h12835B01;
         6'd10: v = 32'h243185BE;  6'd11: v = 32'h550C7DC3;
         6'd12: v = 32'h72BE5D74;  6'd13: v = 32'h80DEB1FE;
         6'd14: v = 32'h9BDC06A7;  6'd15: v = 32'hC19BF174;
         6'd16: v = 32'hE49B69C1;  6'd17: v = 32'hEFBE4786;
         6'd18: v = 32'h0FC19DC6;  6'd19: v = 32'h240CA1CC;
         6'd20: v = 32'h2DE92C6F;  6'd21: v = 32'h4A7484AA;
         6'd22: v = 32'h5CB0A9DC;  6'd23: v = 32'h76F988DA;
         6'd24: v = 32'h983E5152;  6'd25: v = 32'hA831C66D;
         6'd26: v = 32'hB00327C8;  6'd27: v = 32'hBF597FC7;
         6'd28: v = 32'hC6E00BF3;  6'd29: v = 32'hD5A79147;
         6'd30: v = 32'h06CA6351;  6'd31: v = 32'h14292967;
         6'd32: v = 32'h27B70A85;  6'd33: v = 32'h2E1B2138;
         6'd34: v = 32'h4D2C6DFC;  6'd35: v = 32'h53380D13;
         6'd36: v = 32'h650A7354;  6'd37: v = 32'h766A0ABB;
         6'd38: v = 32'h81C2C92E;  6'd39: v = 32'h92722C85;
         6'd40: v = 32'hA2BFE8A1;  6'd41: v = 32'hA81A664B;
         6'd42: v = 32'hC24B8B70;  6'd43: v = 32'hC76C51A3;
         6'd44: v = 32'hD192E819;  6'd45: v = 32'hD6990624;
         6'd46: v = 32'hF40E3585;  6'd47: v = 32'h106AA070;
         6'd48: v = 32'h19A4C116;  6'd49: v = 32'h1E376C08;
         6'd50: v = 32'h2748774C;  6'd51: v = 32'h34B0BCB5;
         6'd52: v = 32'h391C0CB3;  6'd53: v = 32'h4ED8AA4A;
         6'd54: v = 32'h5B9CCA4F;  6'd55: v = 32'h682E6FF3;
         6'd56: v = 32'h748F82EE;  6'd57: v = 32'h78A5636F;
         6'd58: v = 32'h84C87814;  6'd59: v = 32'h8CC70208;
         6'd60: v = 32'h90BEFFFA;  6'd61: v = 32'hA4506CEB;
         6'd62: v = 32'hBEF9A3F7;  6'd63: v = 32'hC67178F2;
         default: v = 32'h428A2F98;
      endcase
      return v;
   endfunction

endpackage

>>> sv/sha256_stream_hasher.sv
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata[7:0] data_byte, tuser kind
// rsp     | out | rsp_tvalid/rsp_tready | tdata[31:0] digest_word, [34:32] word_index,
//         |     |                       | tlast last_word
// Data bytes are taken one per cycle; every fourth byte becomes a word in a 4-deep queue.
// For each block the core loads 16 words, runs 64 rounds and adds into the hash; the queue
// holds 16 bytes, so the other 48 arrive while the core loads.
// Finish pushes the padding words, runs one or two compressions, then 8 digest transfers.
// Synchronous reset returns the hash words, fill and bit count to their initial values.
// The input stalls when the queue is full; the rsp output register holds under backpressure.
module sha256_stream_hasher import ssh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tuser,   // [0] kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index
   output logic                  rsp_tlast
);

   logic        q_full, q_empty, q_push, q_pop;
   q_entry_type push_entry, pop_entry;

   ssh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   ssh_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   ssh_core u_core (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> sv/ssh_front.sv
module ssh_front import ssh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        q_full,
   output logic        q_push,
   output q_entry_type q_entry
);

   front_state_type state_ff, state_in;
   logic [31:0] acc_ff, acc_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bit_count_ff, bit_count_in;
   logic [63:0] total_ff, total_in;
   logic [3:0]  widx_ff, widx_in;
   logic [1:0]  part_ff, part_in;
   logic        len_ok_ff, len_ok_in;
   logic        accept;
   logic [31:0] first_word;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      case (part_ff)
         2'd0: first_word = 32'h8000_0000;
         2'd1: first_word = {acc_ff[7:0], 8'h80, 16'h0};
         2'd2: first_word = {acc_ff[15:0], 8'h80, 8'h0};
         2'd3: first_word = {acc_ff[23:0], 8'h80};
         default: first_word = 32'h8000_0000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FRONT_IDLE;
         fill_ff      <= '0;
         bit_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bit_count_ff <= bit_count_in;
      end
      acc_ff    <= acc_in;
      total_ff  <= total_in;
      widx_ff   <= widx_in;
      part_ff   <= part_in;
      len_ok_ff <= len_ok_in;
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      fill_in      = fill_ff;
      bit_count_in = bit_count_ff;
      total_in     = total_ff;
      widx_in      = widx_ff;
      part_in      = part_ff;
      len_ok_in    = len_ok_ff;
      req_tready   = 1'b0;
      q_push       = 1'b0;
      q_entry      = '{word: {acc_ff[23:0], req_tdata}, final_word: 1'b0};
      case (state_ff)
         FRONT_IDLE: begin
            req_tready = !q_full;
            if (accept) begin
               if (req_tuser == KIND_DATA) begin
                  acc_in  = {acc_ff[23:0], req_tdata};
                  fill_in = fill_ff + 6'd1;
                  q_push  = (fill_ff[1:0] == 2'd3);
                  if (fill_ff == 6'd63) begin
                     bit_count_in = bit_count_ff + 64'd512;
                  end
               end else begin
                  total_in     = bit_count_ff + {55'd0, fill_ff, 3'd0};
                  widx_in      = fill_ff[5:2];
                  part_in      = fill_ff[1:0];
                  len_ok_in    = (fill_ff[5:2] < 4'd14);
                  fill_in      = '0;
                  bit_count_in = '0;
                  state_in     = FRONT_PAD_FIRST;
               end
            end
         end
         FRONT_PAD_FIRST: begin
            q_entry = '{word: first_word, final_word: 1'b0};
            if (!q_full) begin
               q_push   = 1'b1;
               widx_in  = widx_ff + 4'd1;
               len_ok_in = len_ok_ff || (widx_ff == 4'd15);
               state_in = FRONT_PAD_FILL;
            end
         end
         FRONT_PAD_FILL: begin
            if (len_ok_ff && widx_ff == 4'd14) begin
               q_entry = '{word: total_ff[63:32], final_word: 1'b0};
            end else if (len_ok_ff && widx_ff == 4'd15) begin
               q_entry = '{word: total_ff[31:0], final_word: 1'b1};
            end else begin
               q_entry = '{word: 32'h0, final_word: 1'b0};
            end
            if (!q_full) begin
               q_push    = 1'b1;
               widx_in   = widx_ff + 4'd1;
               len_ok_in = len_ok_ff || (widx_ff == 4'd15);
               if (q_entry.final_word) begin
                  state_in = FRONT_IDLE;
               end
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

endmodule

>>> sv/ssh_fifo.sv
module ssh_fifo import ssh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   output logic        full,
   input  logic        pop,
   output q_entry_type pop_entry,
   output logic        empty
);

   q_entry_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> sv/ssh_core.sv
module ssh_core import ssh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  q_entry_type           q_entry,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   core_state_type state_ff, state_in;
   logic [31:0] hash_ff [8];
   logic [31:0] hash_in [8];
   logic [31:0] vars_ff [8];
   logic [31:0] vars_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [3:0]  load_cnt_ff, load_cnt_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  emit_idx_ff, emit_idx_in;
   logic        final_ff, final_in;
   logic        out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic        out_last_ff, out_last_in;
   logic [31:0] t1, t2, w_next;
   logic        out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign out_free   = !out_valid_ff || rsp_tready;

   assign t1 = vars_ff[7] + big_sigma1(vars_ff[4])
             + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
             + round_k(round_ff) + w_ff[0];
   assign t2 = big_sigma0(vars_ff[0])
             + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                ^ (vars_ff[1] & vars_ff[2]));
   assign w_next = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CORE_LOAD;
         load_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
         for (int j = 0; j < 8; j++) begin
            hash_ff[j] <= initial_hash(3'(j));
         end
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         out_valid_ff <= out_valid_in;
         hash_ff      <= hash_in;
      end
      vars_ff     <= vars_in;
      w_ff        <= w_in;
      round_ff    <= round_in;
      emit_idx_ff <= emit_idx_in;
      final_ff    <= final_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      vars_in      = vars_ff;
      w_in         = w_ff;
      load_cnt_in  = load_cnt_ff;
      round_in     = round_ff;
      emit_idx_in  = emit_idx_ff;
      final_in     = final_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      case (state_ff)
         CORE_LOAD: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               for (int j = 0; j < 15; j++) begin
                  w_in[j] = w_ff[j+1];
               end
               w_in[15]    = q_entry.word;
               load_cnt_in = load_cnt_ff + 4'd1;
               if (load_cnt_ff == 4'd15) begin
                  final_in = q_entry.final_word;
                  vars_in  = hash_ff;
                  round_in = '0;
                  state_in = CORE_ROUND;
               end
            end
         end
         CORE_ROUND: begin
            vars_in[7] = vars_ff[6];
            vars_in[6] = vars_ff[5];
            vars_in[5] = vars_ff[4];
            vars_in[4] = vars_ff[3] + t1;
            vars_in[3] = vars_ff[2];
            vars_in[2] = vars_ff[1];
            vars_in[1] = vars_ff[0];
            vars_in[0] = t1 + t2;
            for (int j = 0; j < 15; j++) begin
               w_in[j] = w_ff[j+1];
            end
            w_in[15] = w_next;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = CORE_ADD;
            end
         end
         CORE_ADD: begin
            for (int j = 0; j < 8; j++) begin
               hash_in[j] = hash_ff[j] + vars_ff[j];
            end
            emit_idx_in = '0;
            state_in    = final_ff ? CORE_EMIT : CORE_LOAD;
         end
         CORE_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = {5'd0, emit_idx_ff, hash_ff[0]};
               out_last_in  = (emit_idx_ff == 3'd7);
               for (int j = 0; j < 7; j++) begin
                  hash_in[j] = hash_ff[j+1];
               end
               hash_in[7]  = initial_hash(emit_idx_ff);
               emit_idx_in = emit_idx_ff + 3'd1;
               if (emit_idx_ff == 3'd7) begin
                  state_in = CORE_LOAD;
               end
            end
         end
         default: state_in = CORE_LOAD;
      endcase
   end

endmodule

>>> sv/ssh_checker.sv
module ssh_checker import ssh_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [7:0]            req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid |-> !$isunknown(req_tready)
                     && (!req_tready || !$isunknown({req_tuser, req_tdata})))
      else $error("unknown req transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   a_last_on_word7: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd7)))
      else $error("tlast does not match word index");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39:35] == 5'd0))
      else $error("nonzero tdata pad bits");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind sha256_stream_hasher ssh_checker u_ssh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
